[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, property written out by the caller
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mlin_pkg.sv]
`timescale 1ns / 1ps

package mlin_pkg;

  localparam int WINDOW       = 5;
  localparam int TABLE_POINTS = 17;
  localparam int RD_W         = 10;
  localparam int DIST_W       = 11;
  localparam int STATUS_W     = 2;
  localparam int NUM_REGS     = 3;
  localparam int DATA_W       = 32;

  localparam int HALF      = WINDOW / 2;
  localparam int IDX_W     = $clog2(WINDOW);
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int PT_W      = $clog2(TABLE_POINTS);
  localparam int SEG_W     = (TABLE_POINTS > 2) ? $clog2(TABLE_POINTS - 1) : 1;
  localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam logic [RD_W-1:0] RST_DISC = RD_W'(30);
  localparam logic [RD_W-1:0] RST_FAR  = RD_W'(92);
  localparam logic [RD_W-1:0] RST_NEAR = RD_W'(512);

  // readings ascend, distances descend
  localparam logic [RD_W-1:0] LUT_READING [TABLE_POINTS] = '{
    92, 98, 106, 115, 123, 133, 147, 164, 180,
    205, 235, 262, 297, 327, 368, 440, 512
  };
  localparam logic [DIST_W-1:0] LUT_DIST [TABLE_POINTS] = '{
    1500, 1400, 1300, 1200, 1100, 1000, 900, 800, 700,
    600, 500, 450, 400, 350, 300, 250, 200
  };

  // largest (d0 - d1) * (a1 - a0) over all segments: bounds the dividend
  function automatic int max_product();
    int m;
    int p;
    m = 0;
    for (int i = 0; i < TABLE_POINTS - 1; i++) begin
      p = (int'(LUT_DIST[i]) - int'(LUT_DIST[i+1])) *
          (int'(LUT_READING[i+1]) - int'(LUT_READING[i]));
      if (p > m) m = p;
    end
    return m;
  endfunction

  localparam int PROD_W    = $clog2(max_product() + 1);
  localparam int ALU_W0    = (PROD_W > DIST_W) ? PROD_W : DIST_W;
  localparam int ALU_W     = (ALU_W0 > RD_W) ? ALU_W0 : RD_W;
  localparam int DIV_CNT_W = (PROD_W > 1) ? $clog2(PROD_W) : 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NEAR = 2'd1,
    ST_FAR  = 2'd2,
    ST_DISC = 2'd3
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DISC = 0,
    REG_FAR  = 1,
    REG_NEAR = 2
  } reg_idx_e;

  typedef enum logic {
    CMD_STORE  = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [RD_W-1:0] disc;
    logic [RD_W-1:0] far_thr;
    logic [RD_W-1:0] near_thr;
  } thr_cfg_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } alu_flags_t;

  typedef logic [WINDOW-1:0][RD_W-1:0] window_t;

endpackage

[hdl/mlin_alu.sv]
`timescale 1ns / 1ps

module mlin_alu (
  input  logic [mlin_pkg::ALU_W-1:0] a_i,
  input  logic [mlin_pkg::ALU_W-1:0] b_i,
  output logic [mlin_pkg::ALU_W-1:0] diff_o,
  output mlin_pkg::alu_flags_t       flags_o
);
  import mlin_pkg::*;

  logic [ALU_W:0] full;

  assign full          = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o        = full[ALU_W-1:0];
  assign flags_o.lt    = full[ALU_W];
  assign flags_o.eq    = (a_i == b_i);

endmodule

[hdl/mlin_ring.sv]
`timescale 1ns / 1ps

module mlin_ring (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      store_i,
  input  logic [mlin_pkg::RD_W-1:0] sample_i,
  output mlin_pkg::window_t         window_o,
  output logic                      full_o
);
  import mlin_pkg::*;

  window_t          ring_q;
  logic [CNT_W-1:0] fill_q, fill_d;

  // oldest entry drops out, same set as overwriting at the write pointer
  always_ff @(posedge clk_i) begin
    if (store_i) begin
      ring_q <= {ring_q[WINDOW-2:0], sample_i};
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (store_i && !full_o) fill_d = fill_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign full_o   = (fill_q == CNT_W'(WINDOW));
  assign window_o = ring_q;

endmodule

[hdl/mlin_regs.sv]
`timescale 1ns / 1ps

module mlin_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlin_pkg::ADDR_W-1:0] paddr,
  input  logic [mlin_pkg::DATA_W-1:0] pwdata,
  output logic [mlin_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mlin_pkg::thr_cfg_t          cfg_o
);
  import mlin_pkg::*;

  thr_cfg_t               cfg_q, cfg_d;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DISC: cfg_d.disc     = pwdata[RD_W-1:0];
        REG_FAR:  cfg_d.far_thr  = pwdata[RD_W-1:0];
        REG_NEAR: cfg_d.near_thr = pwdata[RD_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disc     <= RST_DISC;
      cfg_q.far_thr  <= RST_FAR;
      cfg_q.near_thr <= RST_NEAR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_DISC: prdata = DATA_W'(cfg_q.disc);
      REG_FAR:  prdata = DATA_W'(cfg_q.far_thr);
      REG_NEAR: prdata = DATA_W'(cfg_q.near_thr);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/median_lut_distance_linearizer_unit.sv]
`timescale 1ns / 1ps

// Median-of-five distance linearizer. A store item (cmd 0) shifts its reading
// into the five-entry window and gives no result. A report item (cmd 1)
// before five samples are stored is taken and gives no result. A report on a
// full window runs a sequencer around a single shared subtract/compare unit:
// the median search (one compare per cycle, a pass of five per candidate),
// threshold checks, a check against the table start, the table search, then
// an offset, a multiply, a 12-step restoring divide, a subtract and a load of
// the output register. in_ready_o stays low from when such a report is taken
// until its result is loaded into the output register, which waits while an
// earlier result is not yet collected. The result waits in an output
// register, so stores are taken while it is not yet collected. Threshold
// registers sit at byte addresses 0 (disconnect), 4 (far) and 8 (near) and
// reset to 30, 92, 512.
module median_lut_distance_linearizer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [mlin_pkg::RD_W-1:0]     sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mlin_pkg::STATUS_W-1:0] status_o,
  output logic [mlin_pkg::DIST_W-1:0]   distance_o,
  output logic [mlin_pkg::RD_W-1:0]     median_reading_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlin_pkg::ADDR_W-1:0]   paddr,
  input  logic [mlin_pkg::DATA_W-1:0]   pwdata,
  output logic [mlin_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mlin_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MED, S_DISC, S_FAR, S_NEAR, S_BASE, S_SEARCH,
    S_OFF, S_MUL, S_DIV, S_SUB, S_OUT
  } state_e;

  state_e               state_q, state_d;
  window_t              work_q, work_d;
  logic [RD_W-1:0]      cand_q, cand_d;
  logic [IDX_W-1:0]     j_q, j_d;
  logic [CNT_W-1:0]     lt_cnt_q, lt_cnt_d, le_cnt_q, le_cnt_d;
  logic [RD_W-1:0]      med_q, med_d;
  logic [SEG_W-1:0]     seg_q, seg_d;
  logic [RD_W-1:0]      off_q, off_d;
  logic [PROD_W-1:0]    prod_q, prod_d, quo_q, quo_d;
  logic [ALU_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  status_e              res_status_q, res_status_d;
  logic [DIST_W-1:0]    res_dist_q, res_dist_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [DIST_W-1:0]    dist_q, dist_d;
  logic [RD_W-1:0]      median_q, median_d;

  thr_cfg_t             cfg;
  window_t              window;
  logic                 full;
  logic                 accept;
  logic                 store;

  logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
  alu_flags_t           flags;

  window_t              rot1, rot2;
  logic [CNT_W-1:0]     lt_n, le_n;
  logic [PT_W-1:0]      seg_lo, seg_hi;
  logic [RD_W-1:0]      a0, a1, span;
  logic [DIST_W-1:0]    d0, dd;
  logic [DIST_W+RD_W-1:0] prod_full;
  logic [ALU_W-1:0]     rem_sh;

  mlin_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign store      = accept && (cmd_i == CMD_STORE);

  mlin_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .store_i  (store),
    .sample_i (sample_i),
    .window_o (window),
    .full_o   (full)
  );

  mlin_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .diff_o  (alu_diff),
    .flags_o (flags)
  );

  assign rot1      = {work_q[WINDOW-2:0], work_q[WINDOW-1]};
  assign rot2      = {rot1[WINDOW-2:0], rot1[WINDOW-1]};
  assign lt_n      = lt_cnt_q + CNT_W'(flags.lt);
  assign le_n      = le_cnt_q + CNT_W'(flags.lt | flags.eq);
  assign seg_lo    = PT_W'(seg_q);
  assign seg_hi    = PT_W'(seg_q) + PT_W'(1);
  assign a0        = LUT_READING[seg_lo];
  assign a1        = LUT_READING[seg_hi];
  assign span      = a1 - a0;
  assign d0        = LUT_DIST[seg_lo];
  assign dd        = d0 - LUT_DIST[seg_hi];
  assign prod_full = (DIST_W+RD_W)'(dd) * (DIST_W+RD_W)'(off_q);
  assign rem_sh    = {rem_q[ALU_W-2:0], prod_q[PROD_W-1]};

  always_comb begin
    case (state_q)
      S_MED: begin
        alu_a = ALU_W'(work_q[0]);
        alu_b = ALU_W'(cand_q);
      end
      S_DISC: begin
        alu_a = ALU_W'(med_q);
        alu_b = ALU_W'(cfg.disc);
      end
      S_FAR: begin
        alu_a = ALU_W'(med_q);
        alu_b = ALU_W'(cfg.far_thr);
      end
      S_NEAR: begin
        alu_a = ALU_W'(cfg.near_thr);
        alu_b = ALU_W'(med_q);
      end
      S_BASE: begin
        alu_a = ALU_W'(med_q);
        alu_b = ALU_W'(LUT_READING[0]);
      end
      S_SEARCH: begin
        alu_a = ALU_W'(a1);
        alu_b = ALU_W'(med_q);
      end
      S_OFF: begin
        alu_a = ALU_W'(med_q);
        alu_b = ALU_W'(a0);
      end
      S_DIV: begin
        alu_a = rem_sh;
        alu_b = ALU_W'(span);
      end
      S_SUB: begin
        alu_a = ALU_W'(d0);
        alu_b = ALU_W'(quo_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    work_d       = work_q;
    cand_d       = cand_q;
    j_d          = j_q;
    lt_cnt_d     = lt_cnt_q;
    le_cnt_d     = le_cnt_q;
    med_d        = med_q;
    seg_d        = seg_q;
    off_d        = off_q;
    prod_d       = prod_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    res_status_d = res_status_q;
    res_dist_d   = res_dist_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    dist_d       = dist_q;
    median_d     = median_q;

    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_REPORT) && full) begin
          work_d   = window;
          cand_d   = window[0];
          j_d      = '0;
          lt_cnt_d = '0;
          le_cnt_d = '0;
          state_d  = S_MED;
        end
      end
      S_MED: begin
        if (j_q == IDX_W'(WINDOW - 1)) begin
          if ((lt_n <= CNT_W'(HALF)) && (le_n >= CNT_W'(HALF + 1))) begin
            med_d   = cand_q;
            state_d = S_DISC;
          end else begin
            // one extra step so the next pass starts on the next candidate
            work_d   = rot2;
            cand_d   = rot2[0];
            j_d      = '0;
            lt_cnt_d = '0;
            le_cnt_d = '0;
          end
        end else begin
          work_d   = rot1;
          j_d      = j_q + IDX_W'(1);
          lt_cnt_d = lt_n;
          le_cnt_d = le_n;
        end
      end
      S_DISC: begin
        if (flags.lt) begin
          res_status_d = ST_DISC;
          res_dist_d   = '0;
          state_d      = S_OUT;
        end else begin
          state_d = S_FAR;
        end
      end
      S_FAR: begin
        if (flags.lt) begin
          res_status_d = ST_FAR;
          res_dist_d   = '0;
          state_d      = S_OUT;
        end else begin
          state_d = S_NEAR;
        end
      end
      S_NEAR: begin
        if (flags.lt) begin
          res_status_d = ST_NEAR;
          res_dist_d   = '0;
          state_d      = S_OUT;
        end else begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        if (flags.lt) begin
          res_status_d = ST_FAR;
          res_dist_d   = '0;
          state_d      = S_OUT;
        end else begin
          seg_d   = '0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (flags.lt) begin
          if (seg_q == SEG_W'(TABLE_POINTS - 2)) begin
            res_status_d = ST_FAR;
            res_dist_d   = '0;
            state_d      = S_OUT;
          end else begin
            seg_d = seg_q + SEG_W'(1);
          end
        end else begin
          state_d = S_OFF;
        end
      end
      S_OFF: begin
        off_d   = alu_diff[RD_W-1:0];
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d    = prod_full[PROD_W-1:0];
        rem_d     = '0;
        quo_d     = '0;
        div_cnt_d = '0;
        state_d   = (span == '0) ? S_SUB : S_DIV;
      end
      S_DIV: begin
        if (!flags.lt) begin
          rem_d = alu_diff;
          quo_d = {quo_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[PROD_W-2:0], 1'b0};
        end
        prod_d = {prod_q[PROD_W-2:0], 1'b0};
        if (div_cnt_q == DIV_CNT_W'(PROD_W - 1)) begin
          state_d = S_SUB;
        end else begin
          div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        end
      end
      S_SUB: begin
        res_status_d = ST_OK;
        res_dist_d   = alu_diff[DIST_W-1:0];
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          dist_d      = res_dist_q;
          median_d    = med_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      work_q       <= '0;
      cand_q       <= '0;
      j_q          <= '0;
      lt_cnt_q     <= '0;
      le_cnt_q     <= '0;
      med_q        <= '0;
      seg_q        <= '0;
      off_q        <= '0;
      prod_q       <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      res_status_q <= ST_OK;
      res_dist_q   <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      dist_q       <= '0;
      median_q     <= '0;
    end else begin
      state_q      <= state_d;
      work_q       <= work_d;
      cand_q       <= cand_d;
      j_q          <= j_d;
      lt_cnt_q     <= lt_cnt_d;
      le_cnt_q     <= le_cnt_d;
      med_q        <= med_d;
      seg_q        <= seg_d;
      off_q        <= off_d;
      prod_q       <= prod_d;
      quo_q        <= quo_d;
      rem_q        <= rem_d;
      div_cnt_q    <= div_cnt_d;
      res_status_q <= res_status_d;
      res_dist_q   <= res_dist_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      dist_q       <= dist_d;
      median_q     <= median_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign distance_o       = dist_q;
  assign median_reading_o = median_q;

endmodule

[hdl/mlin_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlin_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mlin_pkg::STATUS_W-1:0] status_o,
  input logic [mlin_pkg::DIST_W-1:0]   distance_o,
  input logic [mlin_pkg::RD_W-1:0]     median_reading_o
);
  import mlin_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(median_reading_o) && $stable(distance_o), "result item changed while stalled")

  `ASSERT_IMPL(a_dist_zero, clk_i, rst_ni, out_valid_o && (status_o != ST_OK) |-> (distance_o == '0), "distance set on a non-ok item")

  `ASSERT_IMPL(a_ok_on_table, clk_i, rst_ni, out_valid_o && (status_o == ST_OK) |-> (median_reading_o >= LUT_READING[0]) && (median_reading_o <= LUT_READING[TABLE_POINTS-1]) && (distance_o != '0), "ok item off the table")

  `ASSERT_IMPL(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o), "result item without a busy report")

endmodule

bind median_lut_distance_linearizer_unit mlin_checker u_mlin_checker (.*);
